@@ hw/rtl/afs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and lookup tables for the ADTS frame scanner.
// No dependencies; used by every module under hw/rtl.
package afs_pkg;

    localparam int COUNT_WIDTH   = 16;
    localparam int LEN_W         = 13;
    localparam int RIDX_W        = 4;
    localparam int RATE_W        = 17;
    localparam int DUR_W         = 14;
    localparam int FCNT_W        = 16;
    localparam int OUT_DATA_W    = 64;
    localparam int WIN_DEPTH     = 6;
    localparam int FILL_W        = 3;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]        SYNC_BYTE   = 8'hFF;
    localparam logic [7:0]        SYNC2_MASK  = 8'hF6;
    localparam logic [7:0]        SYNC2_VALUE = 8'hF0;
    localparam logic [RIDX_W-1:0] RIDX_COUNT  = 4'd13;
    localparam logic [LEN_W-1:0]  HDR_LEN     = 13'd7;
    localparam logic [DUR_W-1:0]  DUR_DEFAULT = 14'd1920;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic {
        KIND_FRAME   = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    // one accepted byte's worth of results: an optional frame report and
    // an optional end-of-buffer summary
    typedef struct packed {
        logic              frame_valid;
        logic              sum_valid;
        logic [LEN_W-1:0]  length;
        logic [RIDX_W-1:0] frame_ridx;
        logic [RIDX_W-1:0] sum_ridx;
        logic              sum_seen;
        logic [FCNT_W-1:0] count;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [RATE_W-1:0] rate_of(input logic [RIDX_W-1:0] idx);
        logic [RATE_W-1:0] r;
        case (idx)
            4'd0:    r = 17'd96000;
            4'd1:    r = 17'd88200;
            4'd2:    r = 17'd64000;
            4'd3:    r = 17'd48000;
            4'd4:    r = 17'd44100;
            4'd5:    r = 17'd32000;
            4'd6:    r = 17'd24000;
            4'd7:    r = 17'd22050;
            4'd8:    r = 17'd16000;
            4'd9:    r = 17'd12000;
            4'd10:   r = 17'd11025;
            4'd11:   r = 17'd8000;
            4'd12:   r = 17'd7350;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // 1024 samples in 90 kHz ticks, rounded to nearest
    function automatic logic [DUR_W-1:0] dur_of(input logic [RIDX_W-1:0] idx);
        logic [DUR_W-1:0] d;
        case (idx)
            4'd0:    d = 14'd960;
            4'd1:    d = 14'd1045;
            4'd2:    d = 14'd1440;
            4'd3:    d = 14'd1920;
            4'd4:    d = 14'd2090;
            4'd5:    d = 14'd2880;
            4'd6:    d = 14'd3840;
            4'd7:    d = 14'd4180;
            4'd8:    d = 14'd5760;
            4'd9:    d = 14'd7680;
            4'd10:   d = 14'd8359;
            4'd11:   d = 14'd11520;
            4'd12:   d = 14'd12539;
            default: d = DUR_DEFAULT;
        endcase
        return d;
    endfunction

endpackage

@@ hw/rtl/adts_frame_scanner.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Handshake          Payload
// s_axis   in   tvalid/tready      tdata[7:0] data_byte, tlast end_of_buffer
// m_axis   out  tvalid/tready      tdata: see port, tuser kind, tlast last_of_run
//
// One byte per cycle is taken while the job queue has room; bytes that end a
// frame or a buffer push one job, which the back end turns into one or two
// results, one per cycle while the output is ready; a byte with both a frame and a
// summary yields a frame report, then a summary. Each job passes the queue and the
// output register. Reset clears all scan state, the queue and the output valid flag.
// A stalled output fills the two-entry queue before input ready drops.
// Top level of the ADTS frame scanner; uses afs_pkg, afs_front, afs_queue, afs_back.
module adts_frame_scanner (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [12:0] frame_length, [16:13] rate_index, [33:17] rate_hz,
    // [47:34] frame_duration, [63:48] frame_count
    output logic [afs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tuser,  // [0] kind
    output logic                           m_axis_tlast
);

    afs_pkg::job_t      push_job;
    afs_pkg::job_t      head;
    afs_pkg::q_status_t status;
    logic               push;
    logic               pop;
    logic               accept;

    assign s_axis_tready = !status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    afs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (s_axis_tdata),
        .end_of_buffer (s_axis_tlast),
        .push          (push),
        .job           (push_job)
    );

    afs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (status)
    );

    afs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .status        (status),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ hw/rtl/afs_front.sv @@
`timescale 1ns / 1ps
// Front end: header window, sync/header check, frame byte counting and
// frame tally. Emits one job per byte that causes results. Uses afs_pkg.
module afs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              end_of_buffer,
    output logic              push,
    output afs_pkg::job_t     job
);

    logic [7:0]                      win_reg [afs_pkg::WIN_DEPTH];
    logic [7:0]                      win_next [afs_pkg::WIN_DEPTH];
    logic [afs_pkg::FILL_W-1:0]      fill_reg, fill_next;
    logic                            in_frame_reg, in_frame_next;
    logic [afs_pkg::LEN_W-1:0]       left_reg, left_next;
    logic [afs_pkg::LEN_W-1:0]       cur_len_reg, cur_len_next;
    logic [afs_pkg::RIDX_W-1:0]      cur_ridx_reg, cur_ridx_next;
    logic [afs_pkg::COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [afs_pkg::RIDX_W-1:0]      last_ridx_reg, last_ridx_next;
    logic                            seen_reg, seen_next;

    logic [afs_pkg::RIDX_W-1:0]      hdr_ridx;
    logic [afs_pkg::LEN_W-1:0]       hdr_len;
    logic                            hdr_ok;
    logic                            done;
    logic [afs_pkg::LEN_W-1:0]       frame_len;
    logic [afs_pkg::RIDX_W-1:0]      frame_ridx;
    logic [afs_pkg::COUNT_WIDTH-1:0] cnt_after;

    assign hdr_ridx = win_reg[2][5:2];
    assign hdr_len  = {win_reg[3][1:0], win_reg[4], win_reg[5][7:5]};
    assign hdr_ok   = (win_reg[0] == afs_pkg::SYNC_BYTE)
                   && ((win_reg[1] & afs_pkg::SYNC2_MASK) == afs_pkg::SYNC2_VALUE)
                   && (hdr_ridx < afs_pkg::RIDX_COUNT)
                   && (hdr_len >= afs_pkg::HDR_LEN);

    always_comb
    begin
        for (int i = 0; i < afs_pkg::WIN_DEPTH; i++)
        begin
            win_next[i] = win_reg[i];
        end
        fill_next      = fill_reg;
        in_frame_next  = in_frame_reg;
        left_next      = left_reg;
        cur_len_next   = cur_len_reg;
        cur_ridx_next  = cur_ridx_reg;
        last_ridx_next = last_ridx_reg;
        seen_next      = seen_reg;
        done           = 1'b0;
        frame_len      = cur_len_reg;
        frame_ridx     = cur_ridx_reg;

        if (in_frame_reg)
        begin
            left_next = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
            done      = (left_reg <= afs_pkg::LEN_W'(1));
        end
        else if (fill_reg < afs_pkg::FILL_W'(afs_pkg::WIN_DEPTH))
        begin
            for (int i = 0; i < afs_pkg::WIN_DEPTH; i++)
            begin
                if (fill_reg == afs_pkg::FILL_W'(i))
                begin
                    win_next[i] = data_byte;
                end
            end
            fill_next = fill_reg + 1'b1;
        end
        else if (hdr_ok)
        begin
            in_frame_next = 1'b1;
            cur_len_next  = hdr_len;
            cur_ridx_next = hdr_ridx;
            left_next     = hdr_len - afs_pkg::HDR_LEN;
            fill_next     = '0;
            frame_len     = hdr_len;
            frame_ridx    = hdr_ridx;
            done          = (hdr_len == afs_pkg::HDR_LEN);
        end
        else
        begin
            // bad header: drop oldest byte, new byte becomes the sixth
            for (int i = 0; i < afs_pkg::WIN_DEPTH - 1; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[afs_pkg::WIN_DEPTH-1] = data_byte;
        end

        cnt_after = (done && (cnt_reg != afs_pkg::COUNT_MAX)) ? cnt_reg + 1'b1 : cnt_reg;
        cnt_next  = cnt_after;
        if (done)
        begin
            last_ridx_next = frame_ridx;
            seen_next      = 1'b1;
            in_frame_next  = 1'b0;
        end

        job.frame_valid = done;
        job.sum_valid   = end_of_buffer;
        job.length      = frame_len;
        job.frame_ridx  = frame_ridx;
        job.sum_ridx    = last_ridx_next;
        job.sum_seen    = seen_next;
        job.count       = afs_pkg::FCNT_W'(cnt_after);

        if (end_of_buffer)
        begin
            for (int i = 0; i < afs_pkg::WIN_DEPTH; i++)
            begin
                win_next[i] = '0;
            end
            fill_next      = '0;
            in_frame_next  = 1'b0;
            left_next      = '0;
            cur_len_next   = '0;
            cur_ridx_next  = '0;
            cnt_next       = '0;
            last_ridx_next = '0;
            seen_next      = 1'b0;
        end
    end

    assign push = accept && (done || end_of_buffer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < afs_pkg::WIN_DEPTH; i++)
            begin
                win_reg[i] <= '0;
            end
            fill_reg      <= '0;
            in_frame_reg  <= 1'b0;
            left_reg      <= '0;
            cur_len_reg   <= '0;
            cur_ridx_reg  <= '0;
            cnt_reg       <= '0;
            last_ridx_reg <= '0;
            seen_reg      <= 1'b0;
        end
        else if (accept)
        begin
            for (int i = 0; i < afs_pkg::WIN_DEPTH; i++)
            begin
                win_reg[i] <= win_next[i];
            end
            fill_reg      <= fill_next;
            in_frame_reg  <= in_frame_next;
            left_reg      <= left_next;
            cur_len_reg   <= cur_len_next;
            cur_ridx_reg  <= cur_ridx_next;
            cnt_reg       <= cnt_next;
            last_ridx_reg <= last_ridx_next;
            seen_reg      <= seen_next;
        end
    end

endmodule

@@ hw/rtl/afs_queue.sv @@
`timescale 1ns / 1ps
// Short job queue between front end and back end.
// Uses afs_pkg for the job type and depth.
module afs_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  afs_pkg::job_t      push_job,
    input  logic               pop,
    output afs_pkg::job_t      head,
    output afs_pkg::q_status_t status
);

    afs_pkg::job_t               mem [afs_pkg::QUEUE_DEPTH];
    logic [afs_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [afs_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [afs_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic                        do_push;
    logic                        do_pop;

    assign status.full  = (count_reg == afs_pkg::QCNT_W'(afs_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == afs_pkg::QPTR_W'(afs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == afs_pkg::QPTR_W'(afs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ hw/rtl/afs_back.sv @@
`timescale 1ns / 1ps
// Back end: splits a job into frame report and summary, looks up rate and
// duration, and holds the result in the output register. Uses afs_pkg.
module afs_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  afs_pkg::job_t                  head,
    input  afs_pkg::q_status_t             status,
    output logic                           pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [afs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);

    logic                           valid_reg, valid_next;
    logic                           phase_reg, phase_next;
    logic [afs_pkg::OUT_DATA_W-1:0] data_reg, data_next;
    logic                           user_reg, user_next;
    logic                           last_reg, last_next;
    logic                           load;
    logic                           emit_frame;
    logic                           seen;
    logic [afs_pkg::RIDX_W-1:0]     ridx;
    logic [afs_pkg::LEN_W-1:0]      len;
    logic [afs_pkg::RATE_W-1:0]     rate;
    logic [afs_pkg::DUR_W-1:0]      dur;

    assign load       = !valid_reg || m_axis_tready;
    assign emit_frame = head.frame_valid && !phase_reg;
    assign seen       = emit_frame || head.sum_seen;
    assign ridx       = emit_frame ? head.frame_ridx : head.sum_ridx;
    assign len        = emit_frame ? head.length : '0;
    assign rate       = seen ? afs_pkg::rate_of(ridx) : '0;
    assign dur        = seen ? afs_pkg::dur_of(ridx) : afs_pkg::DUR_DEFAULT;

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        pop        = 1'b0;
        data_next  = {head.count, dur, rate, ridx, len};
        user_next  = emit_frame ? afs_pkg::KIND_FRAME : afs_pkg::KIND_SUMMARY;
        last_next  = !(emit_frame && head.sum_valid);
        if (load)
        begin
            valid_next = !status.empty;
            if (!status.empty)
            begin
                if (emit_frame && head.sum_valid)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next = 1'b0;
                    pop        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
            user_reg <= user_next;
            last_reg <= last_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = user_reg;
    assign m_axis_tlast  = last_reg;

endmodule

@@ hw/rtl/afs_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for adts_frame_scanner, attached by bind.
// Uses afs_pkg for widths and kind codes.
module afs_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [afs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser,
    input logic                           m_axis_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction changed while stalled");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == afs_pkg::KIND_SUMMARY) |-> m_axis_tlast)
        else $error("summary not marked last");

    a_summary_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == afs_pkg::KIND_SUMMARY)
        |-> (m_axis_tdata[12:0] == '0))
        else $error("summary carries a frame length");

    a_frame_ridx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == afs_pkg::KIND_FRAME)
        |-> (m_axis_tdata[16:13] < afs_pkg::RIDX_COUNT) && (m_axis_tdata[12:0] >= 13'd7))
        else $error("frame report with bad rate index or length");

    a_summary_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
        |=> m_axis_tvalid && (m_axis_tuser == afs_pkg::KIND_SUMMARY))
        else $error("non-final frame report not followed by summary");

endmodule

bind adts_frame_scanner afs_checker u_afs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
